// File: hdl/lkc_pkg.sv
`timescale 1ns / 1ps

package lkc_pkg;

  localparam int unsigned SEED_W   = 17;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SEED_W;

  localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);
  localparam int unsigned LEHMER_MULT = 75;
  localparam logic [SEED_W:0] LEHMER_MOD = (SEED_W+1)'(65537);

  localparam logic [BYTE_W-1:0]   ROT_BASE = BYTE_W'(32);
  localparam logic [BYTE_W-1:0]   ROT_SPAN = BYTE_W'(96);

  localparam logic [CFG_IDX_W-1:0] REG_SEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(1);

endpackage

// File: hdl/lkc_lehmer.sv
`timescale 1ns / 1ps

module lkc_lehmer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_we_i,
  input  logic [lkc_pkg::SEED_W-1:0]  seed_i,
  input  logic                        step_i,
  output logic [lkc_pkg::SEED_W-1:0]  next_value_o
);

  logic [lkc_pkg::SEED_W-1:0] value_q, value_d;
  logic [23:0]                prod;
  logic [lkc_pkg::SEED_W:0]   diff;

  // 65536 == -1 (mod 65537), so x mod 65537 = low half - high half, fixed up once
  always_comb begin
    prod = 24'(value_q) * 24'(lkc_pkg::LEHMER_MULT);
    diff = {2'b00, prod[15:0]} - {10'b0, prod[23:16]};
    if (diff[lkc_pkg::SEED_W]) begin
      diff = diff + lkc_pkg::LEHMER_MOD;
    end
    next_value_o = diff[lkc_pkg::SEED_W-1:0];
  end

  always_comb begin
    value_d = value_q;
    if (seed_we_i) begin
      value_d = seed_i;
    end else if (step_i) begin
      value_d = next_value_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= lkc_pkg::SEED_RESET;
    end else begin
      value_q <= value_d;
    end
  end

endmodule

// File: hdl/lkc_rotate.sv
`timescale 1ns / 1ps

module lkc_rotate (
  input  logic [lkc_pkg::SEED_W-1:0] value_i,
  input  logic                       decrypt_i,
  input  logic [lkc_pkg::BYTE_W-1:0] byte_i,
  output logic [lkc_pkg::BYTE_W-1:0] byte_o
);

  logic [4:0]                       dsum;
  logic [2:0]                       dsum2;
  logic [1:0]                       q_mod3;
  logic [lkc_pkg::OFFSET_W-1:0]     offset;
  logic                             printable;
  logic [lkc_pkg::BYTE_W-1:0]       pos;
  logic [lkc_pkg::BYTE_W-1:0]       rot;

  // value mod 96 = ((value >> 5) mod 3) * 32 + value[4:0]; base-4 digits sum to mod 3
  always_comb begin
    dsum = 5'(value_i[6:5]) + 5'(value_i[8:7]) + 5'(value_i[10:9])
         + 5'(value_i[12:11]) + 5'(value_i[14:13]) + 5'(value_i[16:15]);
    dsum2 = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
    if (dsum2 >= 3'd6) begin
      q_mod3 = 2'(dsum2 - 3'd6);
    end else if (dsum2 >= 3'd3) begin
      q_mod3 = 2'(dsum2 - 3'd3);
    end else begin
      q_mod3 = dsum2[1:0];
    end
    offset = {q_mod3, value_i[4:0]};
  end

  always_comb begin
    printable = !byte_i[7] && (byte_i[6:5] != 2'b00);
    pos       = byte_i - lkc_pkg::ROT_BASE;
    if (decrypt_i) begin
      rot = pos - 8'(offset);
      if (rot[7]) begin
        rot = rot + lkc_pkg::ROT_SPAN;
      end
    end else begin
      rot = pos + 8'(offset);
      if (rot >= lkc_pkg::ROT_SPAN) begin
        rot = rot - lkc_pkg::ROT_SPAN;
      end
    end
    byte_o = printable ? (rot + lkc_pkg::ROT_BASE) : byte_i;
  end

endmodule

// File: hdl/lehmer_keystream_char_rotate_cipher.sv
`timescale 1ns / 1ps

// Byte stream cipher: a Lehmer generator (x*75 mod 65537) steps once per request
// and rotates printable bytes (32..127) by value mod 96; other bytes pass through.
// Throughput is one request per clock while the output is not stalled. The generator steps
// and the byte is captured in an input register when the request is accepted, and
// the rotation is computed into the result register when that register is free. Writing
// register 0 reloads the generator; register 1 selects decrypt (subtract offset).
module lehmer_keystream_char_rotate_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lkc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lkc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lkc_pkg::BYTE_W-1:0]     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lkc_pkg::BYTE_W-1:0]     out_byte_o
);

  logic                          mode_q;
  logic                          s1_valid_q;
  logic [lkc_pkg::BYTE_W-1:0]    s1_byte_q;
  logic                          s1_dec_q;
  logic [lkc_pkg::SEED_W-1:0]    s1_value_q;
  logic                          out_valid_q;
  logic [lkc_pkg::BYTE_W-1:0]    out_byte_q;
  logic [lkc_pkg::SEED_W-1:0]    next_value;
  logic [lkc_pkg::BYTE_W-1:0]    rot_byte;
  logic                          in_fire;
  logic                          s1_advance;
  logic                          seed_we;

  assign seed_we    = cfg_we_i && (cfg_idx_i == lkc_pkg::REG_SEED);
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  lkc_lehmer u_lehmer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we),
    .seed_i       (cfg_data_i),
    .step_i       (in_fire),
    .next_value_o (next_value)
  );

  lkc_rotate u_rotate (
    .value_i   (s1_value_q),
    .decrypt_i (s1_dec_q),
    .byte_i    (s1_byte_q),
    .byte_o    (rot_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == lkc_pkg::REG_MODE)) begin
        mode_q <= cfg_data_i[0];
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= data_byte_i;
      s1_dec_q   <= mode_q;
      s1_value_q <= next_value;
    end
    if (s1_advance) begin
      out_byte_q <= rot_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

// File: hdl/lkc_checker.sv
`timescale 1ns / 1ps

module lkc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic [lkc_pkg::BYTE_W-1:0] out_byte_o
);

  // no result may be shown once reset has been seen by the clock
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // the input side only stalls when a result is waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // an accepted request reaches the output if the sink keeps up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted request did not reach output");

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");

endmodule

bind lehmer_keystream_char_rotate_cipher lkc_checker u_lkc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o)
);

// File: dv/lehmer_keystream_char_rotate_cipher_tb.sv
`timescale 1ns / 1ps

module lehmer_keystream_char_rotate_cipher_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned PHASE_ITEMS    = 145;
  localparam logic [lkc_pkg::BYTE_W-1:0] ROT_TOP = lkc_pkg::BYTE_W'(127);

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [lkc_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = lkc_pkg::REG_SEED;
  logic [lkc_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [lkc_pkg::BYTE_W-1:0]     data_byte_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [lkc_pkg::BYTE_W-1:0]     out_byte_o;

  // cipher model state
  logic [lkc_pkg::SEED_W-1:0]     keystream_val = lkc_pkg::SEED_RESET;
  logic                           decrypt_sel   = 1'b0;

  logic [lkc_pkg::BYTE_W-1:0]     byte_queue[$];
  logic [lkc_pkg::BYTE_W-1:0]     cipher_bytes_due[$];
  int unsigned                    send_idle_pct  = 0;
  int unsigned                    recv_stall_pct = 0;
  bit                             hold_armed     = 1'b0;
  bit                             hold_taken;
  int unsigned                    hold_left;
  int unsigned                    quiet_cycles   = 0;
  int unsigned                    fail_cnt       = 0;

  lehmer_keystream_char_rotate_cipher u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [lkc_pkg::SEED_W-1:0] lehmer_next(logic [lkc_pkg::SEED_W-1:0] v);
    int unsigned prod;
    prod = int'(v) * lkc_pkg::LEHMER_MULT;
    return lkc_pkg::SEED_W'(prod % int'(lkc_pkg::LEHMER_MOD));
  endfunction

  function automatic logic [lkc_pkg::BYTE_W-1:0] shift_printable(
      logic [lkc_pkg::BYTE_W-1:0]   b,
      logic [lkc_pkg::OFFSET_W-1:0] ofs,
      logic                         dec);
    int unsigned pos;
    if (b < lkc_pkg::ROT_BASE || b > ROT_TOP) return b;
    pos = b - lkc_pkg::ROT_BASE;
    if (dec) pos = (pos + lkc_pkg::ROT_SPAN - ofs) % lkc_pkg::ROT_SPAN;
    else pos = (pos + ofs) % lkc_pkg::ROT_SPAN;
    return lkc_pkg::BYTE_W'(pos + lkc_pkg::ROT_BASE);
  endfunction

  function automatic logic [lkc_pkg::BYTE_W-1:0] rand_byte();
    // lean on the printable range, where the rotation happens
    if ($urandom_range(1) == 0)
      return lkc_pkg::BYTE_W'($urandom_range(ROT_TOP, lkc_pkg::ROT_BASE));
    return lkc_pkg::BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [lkc_pkg::CFG_DATA_W-1:0] rand_seed();
    case ($urandom_range(9))
      0: return '0;
      1: return lkc_pkg::CFG_DATA_W'($urandom_range(131071, 65537));
      default: return lkc_pkg::CFG_DATA_W'($urandom_range(65536, 1));
    endcase
  endfunction

  // Sender: new request only when the line is free or the last one went through
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= byte_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off when armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Generator steps on every accepted request, printable or not
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      keystream_val = lehmer_next(keystream_val);
      cipher_bytes_due.push_back(shift_printable(data_byte_i,
                                 lkc_pkg::OFFSET_W'(keystream_val % lkc_pkg::ROT_SPAN),
                                 decrypt_sel));
    end
  end

  always @(posedge clk_i) begin : check_out
    logic [lkc_pkg::BYTE_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_bytes_due.size() == 0) begin
        $error("out_byte: no result expected, actual %0d", out_byte_o);
        fail_cnt++;
      end else begin
        want = cipher_bytes_due.pop_front();
        if (out_byte_o !== want) begin
          $error("out_byte: expected %0d actual %0d", want, out_byte_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[lehmer_keystream_char_rotate_cipher] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [lkc_pkg::CFG_IDX_W-1:0]  idx,
                           logic [lkc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lkc_pkg::REG_SEED) keystream_val = val;
    else decrypt_sel = val[0];
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid_i || cipher_bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_bytes(logic [lkc_pkg::BYTE_W-1:0] list[]);
    foreach (list[i]) byte_queue.push_back(list[i]);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: seed 1, encrypt; range edges on both sides
    send_bytes('{8'd0, 8'd31, 8'd32, 8'd33, 8'd127, 8'd128, 8'd255, 8'd65, 8'd126});

    // zero seed is a fixed point: everything passes through
    write_reg(lkc_pkg::REG_SEED, '0);
    send_bytes('{8'd32, 8'd90, 8'd127, 8'd200});

    // top of the legal seed range, decrypt
    write_reg(lkc_pkg::REG_SEED, lkc_pkg::CFG_DATA_W'(65536));
    write_reg(lkc_pkg::REG_MODE, lkc_pkg::CFG_DATA_W'(1));
    send_bytes('{8'd32, 8'd127, 8'd80, 8'd10});

    // seed above the modulus; mode write with junk in the upper bits
    write_reg(lkc_pkg::REG_SEED, '1);
    write_reg(lkc_pkg::REG_MODE, lkc_pkg::CFG_DATA_W'(17'h1FFFE));
    send_bytes('{8'd32, 8'd127, 8'd64, 8'd170});

    // seed equal to the modulus collapses to zero on the first step
    write_reg(lkc_pkg::REG_SEED, lkc_pkg::CFG_DATA_W'(65537));
    send_bytes('{8'd50, 8'd100, 8'd127});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_reg(lkc_pkg::REG_SEED, rand_seed());
      write_reg(lkc_pkg::REG_MODE, lkc_pkg::CFG_DATA_W'($urandom_range(131071)));
      for (int k = 0; k < PHASE_ITEMS; k++) byte_queue.push_back(rand_byte());
      // back up the pipe while the sender keeps pushing
      if (ph == 0) hold_armed = 1'b1;
      drain();
    end

    if (fail_cnt == 0) $display("[lehmer_keystream_char_rotate_cipher] OK");
    else $display("[lehmer_keystream_char_rotate_cipher] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/lkc_pkg.sv
hdl/lkc_lehmer.sv
hdl/lkc_rotate.sv
hdl/lehmer_keystream_char_rotate_cipher.sv
hdl/lkc_checker.sv
dv/lehmer_keystream_char_rotate_cipher_tb.sv
